FILE: hw/rtl/acft_pkg.sv
// Package with types and constants for the autofire code table.
`default_nettype none
package acft_pkg;
    localparam int PLAYERS          = 4;
    localparam int CODES_PER_PLAYER = 16;
    localparam int RATE_SLOTS       = 6;
    localparam int DEPTH   = PLAYERS * CODES_PER_PLAYER;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDX_W   = (CODES_PER_PLAYER > 1) ? $clog2(CODES_PER_PLAYER) : 1;
    localparam int CNT_W   = $clog2(CODES_PER_PLAYER + 1);
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 64;

    localparam logic [1:0] MODE_SET   = 2'd0;
    localparam logic [1:0] MODE_STEP  = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;
    localparam logic [1:0] MODE_CLEAR = 2'd3;

    localparam logic [2:0] CFG_RATE_COUNT = 3'd0;
    localparam logic [2:0] CFG_PAT_FIRST  = 3'd1;
    localparam logic [2:0] CFG_PAT_LAST   = 3'd5;
    localparam logic [2:0] CFG_LENGTHS    = 3'd6;

    typedef struct packed {
        logic [1:0]  mode;
        logic [1:0]  player;
        logic [31:0] input_code;
        logic [31:0] button_mask;
        logic [2:0]  rate_index;
        logic [31:0] frame_number;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  current_rate;
        logic        fire_bit;
        logic [31:0] stored_buttons;
        logic        dropped;
    } t_out_word;

    typedef struct packed {
        t_in_word word;
        logic     player_ok;
        logic     is_clear;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_queue_head;
endpackage
`default_nettype wire

FILE: hw/rtl/acft_in_if.sv
// Valid/ready channel that carries one input word.
`default_nettype none
interface acft_in_if;
    logic              valid;
    logic              ready;
    acft_pkg::t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/acft_out_if.sv
// Valid/ready channel that carries one result word.
`default_nettype none
interface acft_out_if;
    logic               valid;
    logic               ready;
    acft_pkg::t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/acft_front.sv
// Front end: accepts input words, classifies them and queues them.
`default_nettype none
module acft_front (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    acft_in_if.sink                  i_in,
    input  wire                      i_pop,
    output acft_pkg::t_queue_head    o_head
);
    import acft_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_cmd       n_cmd;
    logic       push;
    logic       pop;

    always_comb begin
        n_cmd.word      = i_in.data;
        n_cmd.player_ok = ({1'b0, i_in.data.player} < 3'(PLAYERS));
        n_cmd.is_clear  = (i_in.data.mode == MODE_CLEAR);
    end

    assign i_in.ready   = i_rst_n && (r_cnt != 2'd2);
    assign push         = i_in.valid && i_in.ready;
    assign pop          = i_pop && (r_cnt != 2'd0);
    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.cmd   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/acft_back.sv
// Back end: registers, entry memory, sequential search, update and fire bit.
`default_nettype none
module acft_back (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire [acft_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire [acft_pkg::CFG_W-1:0]    i_cfg_data,
    input  acft_pkg::t_queue_head        i_head,
    output logic                         o_pop,
    acft_out_if.source                   o_out
);
    import acft_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_DEC  = 3'd3;
    localparam logic [2:0] S_MOD  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]  r_rate_count;
    logic [63:0] r_pat [5];
    logic [34:0] r_lengths;

    logic [66:0] r_mem [DEPTH];
    logic [66:0] r_rdata;
    logic [CNT_W-1:0] r_count [PLAYERS];

    logic [2:0]       r_state;
    t_cmd             r_cmd;
    logic [CNT_W-1:0] r_i;
    logic             r_found;
    logic [IDX_W-1:0] r_pos;
    logic [2:0]       r_srate;
    logic [31:0]      r_sbut;
    t_out_word        r_res;
    logic [7:0]       r_rem;
    logic [31:0]      r_frm;
    logic [4:0]       r_bit;
    logic [6:0]       r_len;
    logic             r_ov;
    t_out_word        r_od;

    logic [2:0]        eff;
    logic [2:0]        rd_rate;
    logic [2:0]        n_rate;
    logic [2:0]        n_rate_eff;
    logic [CNT_W-1:0]  cnt;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] rd_addr;
    logic [6:0]        raw_len;
    logic [6:0]        n_len;
    logic [7:0]        rem_sh;
    logic [7:0]        n_rem;
    logic              out_free;
    logic [2:0]        ps;

    assign eff  = (r_rate_count > 3'(RATE_SLOTS)) ? 3'(RATE_SLOTS) : r_rate_count;
    assign cnt  = r_count[r_cmd.word.player];
    assign base = ADDR_W'(ADDR_W'(r_cmd.word.player) * ADDR_W'(CODES_PER_PLAYER));
    assign rd_addr = base + ADDR_W'(r_i);
    assign rd_rate = (r_found && r_srate < eff) ? r_srate : 3'd0;
    assign out_free = !r_ov || o_out.ready;
    assign o_pop   = (r_state == S_IDLE) && i_head.valid;
    assign o_out.valid = r_ov;
    assign o_out.data  = r_od;

    always_comb begin
        n_rate = r_cmd.word.rate_index;
        if (r_cmd.word.mode == MODE_STEP) begin
            n_rate = rd_rate + 3'd1;
            if (n_rate >= eff) n_rate = 3'd0;
        end
        n_rate_eff = (n_rate < eff) ? n_rate : 3'd0;
    end

    always_comb begin
        case (rd_rate)
            3'd1:    raw_len = r_lengths[6:0];
            3'd2:    raw_len = r_lengths[13:7];
            3'd3:    raw_len = r_lengths[20:14];
            3'd4:    raw_len = r_lengths[27:21];
            3'd5:    raw_len = r_lengths[34:28];
            default: raw_len = 7'd1;
        endcase
        if (raw_len == 7'd0)       n_len = 7'd1;
        else if (raw_len > 7'd64)  n_len = 7'd64;
        else                       n_len = raw_len;
    end

    assign rem_sh = {r_rem[6:0], r_frm[31]};
    assign n_rem  = (rem_sh >= {1'b0, r_len}) ? rem_sh - {1'b0, r_len} : rem_sh;
    assign ps     = r_res.current_rate - 3'd1;

    always_ff @(posedge i_clk) begin
        if (r_state == S_RD) begin
            r_rdata <= r_mem[rd_addr];
        end
        if (r_state == S_DEC && (r_cmd.word.mode == MODE_SET || r_cmd.word.mode == MODE_STEP)) begin
            if (r_found) begin
                r_mem[base + ADDR_W'(r_pos)] <=
                    {r_cmd.word.input_code, n_rate, r_cmd.word.button_mask};
            end else if (cnt < CNT_W'(CODES_PER_PLAYER)) begin
                r_mem[base + ADDR_W'(cnt)] <=
                    {r_cmd.word.input_code, n_rate, r_cmd.word.button_mask};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_count <= 3'd4;
            r_pat[0]     <= 64'd7;
            r_pat[1]     <= 64'd3;
            r_pat[2]     <= 64'd1;
            r_pat[3]     <= 64'd0;
            r_pat[4]     <= 64'd0;
            r_lengths    <= 35'd270565894;
            r_state      <= S_IDLE;
            r_ov         <= 1'b0;
            for (int p = 0; p < PLAYERS; p++) r_count[p] <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RATE_COUNT: r_rate_count <= i_cfg_data[2:0];
                    CFG_LENGTHS:    r_lengths    <= i_cfg_data[34:0];
                    default: begin
                        if (i_cfg_idx >= CFG_PAT_FIRST && i_cfg_idx <= CFG_PAT_LAST)
                            r_pat[i_cfg_idx - CFG_PAT_FIRST] <= i_cfg_data;
                    end
                endcase
            end
            if (r_state == S_OUT && out_free) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_head.valid) begin
                        r_cmd   <= i_head.cmd;
                        r_res   <= '0;
                        r_i     <= '0;
                        r_found <= 1'b0;
                        if (!i_head.cmd.player_ok) begin
                            r_state <= S_OUT;
                        end else if (i_head.cmd.is_clear) begin
                            r_count[i_head.cmd.word.player] <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_state <= (r_i < cnt) ? S_CMP : S_DEC;
                end
                S_CMP: begin
                    if (r_rdata[66:35] == r_cmd.word.input_code) begin
                        r_found <= 1'b1;
                        r_pos   <= r_i[IDX_W-1:0];
                        r_srate <= r_rdata[34:32];
                        r_sbut  <= r_rdata[31:0];
                        r_state <= S_DEC;
                    end else begin
                        r_i     <= r_i + CNT_W'(1);
                        r_state <= S_RD;
                    end
                end
                S_DEC: begin
                    r_state <= S_OUT;
                    if (r_cmd.word.mode == MODE_QUERY) begin
                        r_res.current_rate   <= rd_rate;
                        r_res.stored_buttons <= r_found ? r_sbut : 32'd0;
                        if (rd_rate != 3'd0) begin
                            r_len   <= n_len;
                            r_frm   <= r_cmd.word.frame_number;
                            r_rem   <= '0;
                            r_bit   <= '0;
                            r_state <= S_MOD;
                        end
                    end else if (r_found) begin
                        r_res.current_rate   <= n_rate_eff;
                        r_res.stored_buttons <= r_cmd.word.button_mask;
                    end else if (cnt < CNT_W'(CODES_PER_PLAYER)) begin
                        r_count[r_cmd.word.player] <= cnt + CNT_W'(1);
                        r_res.current_rate   <= n_rate_eff;
                        r_res.stored_buttons <= r_cmd.word.button_mask;
                    end else begin
                        r_res.dropped <= 1'b1;
                    end
                end
                S_MOD: begin
                    r_rem <= n_rem;
                    r_frm <= {r_frm[30:0], 1'b0};
                    r_bit <= r_bit + 5'd1;
                    if (r_bit == 5'd31) begin
                        r_res.fire_bit <= r_pat[ps][n_rem[5:0]];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_od    <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/autofire_code_table.sv
// Top level of the autofire code table.
// Input words arrive on i_in and results leave on o_out, both valid/ready
// channels; a word moves at a clock edge with valid and ready both high.
// Each input word yields exactly one result word, in order.
// The front end queues up to two words so the input side keeps accepting
// while the back end works or the receiver stalls.
// The back end searches the player's entries one at a time, up to 16 in a
// full table, reading each stored entry through the entry memory's
// registered read port (S_RD) and then comparing it (S_CMP). A query on an
// enabled rate adds a bit-serial modulo of all 32 bits of the frame number
// (S_MOD) to find the fire bit. Clear and out-of-range players skip the
// search and go straight to S_OUT. When the receiver stalls the result
// stays in the output register and the back end holds; the queue then
// fills and i_in.ready drops. Configuration writes on i_cfg_we take effect
// at once; the user must make them while the block is idle, which the
// block does not enforce. Reset empties every table, loads register defaults.
`default_nettype none
module autofire_code_table (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_we,
    input  wire [acft_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire [acft_pkg::CFG_W-1:0]     i_cfg_data,
    acft_in_if.sink                       i_in,
    acft_out_if.source                    o_out
);
    import acft_pkg::*;

    t_queue_head head;
    logic        pop;

    acft_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_pop   (pop),
        .o_head  (head)
    );

    acft_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_head     (head),
        .o_pop      (pop),
        .o_out      (o_out)
    );
endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for the autofire code table with a built-in predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import acft_pkg::*;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_cfg_we;
    logic [2:0]      i_cfg_idx;
    logic [63:0]     i_cfg_data;

    acft_in_if  in_ch ();
    acft_out_if out_ch ();

    autofire_code_table u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    // Predictor state.
    logic [2:0]  rate_count_q;
    logic [63:0] pattern_q [1:5];
    logic [34:0] lengths_q;
    int unsigned fill_q [PLAYERS];
    logic [31:0] code_q [PLAYERS][CODES_PER_PLAYER];
    logic [2:0]  rate_q [PLAYERS][CODES_PER_PLAYER];
    logic [31:0] mask_q [PLAYERS][CODES_PER_PLAYER];

    t_in_word  words_to_send [$];
    t_out_word results_due [$];
    int        mismatches;
    int        idle_pct;
    bit        word_taken;
    bit        stall_request;
    int        stall_left;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("tb_top: errors");
        $finish;
    end

    function automatic int unsigned live_rates();
        return (rate_count_q > RATE_SLOTS) ? RATE_SLOTS : rate_count_q;
    endfunction

    function automatic int find_code(int unsigned p, logic [31:0] code);
        for (int i = 0; i < fill_q[p]; i++) begin
            if (code_q[p][i] == code) return i;
        end
        return -1;
    endfunction

    function automatic int unsigned rate_at(int unsigned p, int pos);
        if (pos < 0) return 0;
        return (rate_q[p][pos] >= live_rates()) ? 0 : rate_q[p][pos];
    endfunction

    function automatic bit store_code(int unsigned p, logic [31:0] code, logic [31:0] mask,
                                      logic [2:0] rate);
        int pos;
        pos = find_code(p, code);
        if (pos < 0) begin
            if (fill_q[p] >= CODES_PER_PLAYER) return 1'b1;
            pos = fill_q[p];
            fill_q[p]++;
            code_q[p][pos] = code;
        end
        rate_q[p][pos] = rate;
        mask_q[p][pos] = mask;
        return 1'b0;
    endfunction

    function automatic t_out_word table_outcome(t_in_word w);
        t_out_word   r;
        int unsigned p;
        int unsigned next;
        int unsigned len;
        int          pos;
        r = '0;
        p = {30'd0, w.player};
        if (w.mode == MODE_CLEAR) begin
            fill_q[p] = 0;
        end else begin
            if (w.mode == MODE_SET) begin
                r.dropped = store_code(p, w.input_code, w.button_mask, w.rate_index);
            end else if (w.mode == MODE_STEP) begin
                next = rate_at(p, find_code(p, w.input_code)) + 1;
                if (next >= live_rates()) next = 0;
                r.dropped = store_code(p, w.input_code, w.button_mask, next[2:0]);
            end
            pos = find_code(p, w.input_code);
            r.current_rate = 3'(rate_at(p, pos));
            if (pos >= 0) r.stored_buttons = mask_q[p][pos];
            if (w.mode == MODE_QUERY && r.current_rate > 0 && r.current_rate < 6) begin
                len = 32'((lengths_q >> (7 * (r.current_rate - 1))) & 35'h7f);
                if (len == 0) len = 1;
                if (len > 64) len = 64;
                r.fire_bit = pattern_q[r.current_rate][w.frame_number % len];
            end
        end
        return r;
    endfunction

    // Sender: offers the next queued word at the falling edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || word_taken) begin
            word_taken = 1'b0;
            if (words_to_send.size() > 0 && $urandom_range(99) >= idle_pct) begin
                in_ch.valid <= 1'b1;
                in_ch.data  <= words_to_send.pop_front();
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls plus one long hold-off on request.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (stall_request) begin
            stall_request = 1'b0;
            stall_left = 400;
            out_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Monitor: predicts on input acceptance, checks on output acceptance.
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                results_due.push_back(table_outcome(in_ch.data));
                word_taken = 1'b1;
            end
            if (out_ch.valid && out_ch.ready) begin
                if (results_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected word %h", out_ch.data);
                end else begin
                    want = results_due.pop_front();
                    if (want.current_rate !== out_ch.data.current_rate
                        || want.fire_bit !== out_ch.data.fire_bit
                        || want.stored_buttons !== out_ch.data.stored_buttons
                        || want.dropped !== out_ch.data.dropped) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: expected %h got %h", want, out_ch.data);
                        end
                    end
                end
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        if (idx == CFG_RATE_COUNT) rate_count_q = value[2:0];
        else if (idx == CFG_LENGTHS) lengths_q = value[34:0];
        else pattern_q[idx] = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic push_word(input logic [1:0] mode, input logic [1:0] player,
                             input logic [31:0] code, input logic [31:0] mask,
                             input logic [2:0] rix, input logic [31:0] frame);
        t_in_word w;
        w.mode = mode;
        w.player = player;
        w.input_code = code;
        w.button_mask = mask;
        w.rate_index = rix;
        w.frame_number = frame;
        words_to_send.push_back(w);
    endtask

    task automatic wait_drained();
        while (words_to_send.size() > 0 || in_ch.valid || results_due.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (80) @(posedge i_clk);
    endtask

    function automatic logic [6:0] pick_length();
        case ($urandom_range(4))
            0: return 7'd0;
            1: return 7'd64;
            2: return 7'd127;
            default: return 7'($urandom_range(1, 64));
        endcase
    endfunction

    task automatic random_config(input logic [2:0] count, input bit extreme);
        logic [34:0] lens;
        write_reg(CFG_RATE_COUNT, {61'd0, count});
        for (int s = 1; s <= 5; s++) begin
            write_reg(s[2:0], extreme ? {64{s[0]}} : {$urandom, $urandom});
        end
        for (int s = 0; s < 5; s++) lens[7 * s +: 7] = pick_length();
        write_reg(CFG_LENGTHS, {29'd0, lens});
    endtask

    task automatic random_words(input int n);
        int          pick;
        logic [1:0]  mode;
        logic [31:0] code;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            if (pick < 30) mode = MODE_SET;
            else if (pick < 55) mode = MODE_STEP;
            else if (pick < 97) mode = MODE_QUERY;
            else mode = MODE_CLEAR;
            code = ($urandom_range(9) == 0) ? $urandom : $urandom_range(19);
            push_word(mode, 2'($urandom_range(3)), code, $urandom,
                      3'($urandom_range(7)), $urandom);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        mismatches = 0;
        idle_pct = 23;
        word_taken = 1'b0;
        stall_request = 1'b0;
        stall_left = 0;
        rate_count_q = 3'd4;
        pattern_q[1] = 64'd7;
        pattern_q[2] = 64'd3;
        pattern_q[3] = 64'd1;
        pattern_q[4] = 64'd0;
        pattern_q[5] = 64'd0;
        lengths_q = 35'd270565894;
        for (int p = 0; p < PLAYERS; p++) fill_q[p] = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed words under the reset configuration.
        push_word(MODE_QUERY, 2'd0, 32'hffffffff, 32'h0, 3'd0, 32'h0);
        push_word(MODE_SET, 2'd0, 32'hffffffff, 32'hffffffff, 3'd1, 32'h0);
        push_word(MODE_QUERY, 2'd0, 32'hffffffff, 32'h0, 3'd0, 32'hffffffff);
        push_word(MODE_QUERY, 2'd0, 32'hffffffff, 32'h0, 3'd0, 32'd5);
        push_word(MODE_STEP, 2'd0, 32'hffffffff, 32'h1234, 3'd0, 32'h0);
        push_word(MODE_STEP, 2'd0, 32'hffffffff, 32'h5678, 3'd0, 32'h0);
        push_word(MODE_STEP, 2'd0, 32'hffffffff, 32'h9abc, 3'd0, 32'h0);
        push_word(MODE_SET, 2'd0, 32'h0, 32'h1, 3'd5, 32'h0);
        push_word(MODE_QUERY, 2'd0, 32'h0, 32'h0, 3'd0, 32'h1);
        push_word(MODE_STEP, 2'd0, 32'h0, 32'h2, 3'd7, 32'h0);
        push_word(MODE_STEP, 2'd3, 32'h77, 32'h3, 3'd0, 32'h0);
        for (int i = 0; i < 16; i++) push_word(MODE_SET, 2'd1, i, ~i, 3'd3, 32'h0);
        push_word(MODE_SET, 2'd1, 32'd16, 32'h4, 3'd1, 32'h0);
        push_word(MODE_STEP, 2'd1, 32'd17, 32'h4, 3'd1, 32'h0);
        push_word(MODE_QUERY, 2'd1, 32'd15, 32'h0, 3'd0, 32'h0);
        push_word(MODE_CLEAR, 2'd1, 32'd0, 32'hffffffff, 3'd7, 32'hffffffff);
        push_word(MODE_QUERY, 2'd1, 32'd0, 32'h0, 3'd0, 32'h0);
        random_words(250);
        wait_drained();

        random_config(3'd6, 1'b1);
        stall_request = 1'b1;
        random_words(260);
        wait_drained();

        random_config(3'd7, 1'b0);
        idle_pct = 0;
        random_words(260);
        wait_drained();

        idle_pct = 23;
        random_config(3'd0, 1'b0);
        random_words(120);
        wait_drained();

        random_config(3'd1, 1'b0);
        random_words(120);
        wait_drained();

        random_config(3'($urandom_range(2, 5)), 1'b0);
        random_words(260);
        wait_drained();

        random_config(3'd6, 1'b0);
        random_words(260);
        wait_drained();

        if (mismatches == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule
`default_nettype wire
